### hdl/cst_pkg.sv
// Package for the CSV stream tokenizer: shared constants, codes, types and helpers.
// No dependencies; every other file in hdl/ except cst_ram refers to it by scoped names.
package cst_pkg;

    // Trailing-whitespace hold buffer
    localparam int HOLD_DEPTH = 32;
    localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);

    // Queue between the front and the back (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // Configuration register map and reset values
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] REG_QUOTE = 2'd0;
    localparam logic [CFG_IW-1:0] REG_DELIM = 2'd1;
    localparam logic [CFG_IW-1:0] REG_TRIM  = 2'd2;
    localparam logic [7:0] QUOTE_RESET = 8'd34;
    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic       TRIM_RESET  = 1'b0;

    // Input command codes
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        EV_APPEND    = 2'd0,
        EV_CLEAR     = 2'd1,
        EV_END_FIELD = 2'd2,
        EV_END_ROW   = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [7:0] quote_char;
        logic [7:0] delim_char;
        logic       trim_enable;
    } cfg_t;

    // Classified input word
    typedef struct packed {
        logic       flush;
        logic       is_quote;
        logic       is_delim;
        logic       is_newline;
        logic       is_space;
        logic [7:0] data_byte;
    } token_t;

    typedef struct packed {
        logic               busy;
        logic [HOLD_CW-1:0] held_count;
    } back_status_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c == 8'd9) || (c == 8'd13) || (c == 8'd11) || (c == 8'd12);
    endfunction

endpackage

### hdl/csv_stream_tokenizer_core.sv
// Top level of the CSV stream tokenizer: configuration registers, front, queue, back.
// Depends on cst_pkg, cst_front, cst_queue, cst_back (and cst_ram through cst_back).
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_tvalid/s_tready  s_tdata = data_byte, s_tuser = cmd
//   m_       out        m_tvalid/m_tready  m_tdata = out_byte, m_tuser = {ovf, kind}, m_tlast
//   cfg_     in         cfg_we             cfg_index, cfg_wdata
//
// An item that gives at most one event is popped as one output word; an end field followed
// by an end row gives two words, the end row from S_TAIL; a byte that releases held whitespace
// is popped and starts the hold RAM read, then the held bytes and the byte itself leave as one
// output word per cycle while the output is not stalled. An input word passes the front
// register and a queue slot before the back registers its first event word.
// Reset is synchronous and clears all control state; the hold RAM is not cleared.
// A two-entry queue and the front register absorb output stalls so input keeps flowing.
module csv_stream_tokenizer_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // data_byte
    input  logic                        s_tuser,   // cmd
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // out_byte
    output logic [2:0]                  m_tuser,   // event_kind[1:0], hold_overflow
    output logic                        m_tlast,   // last
    input  logic                        cfg_we,
    input  logic [cst_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [7:0]                  cfg_wdata
);

    cst_pkg::cfg_t         cfg_reg;
    cst_pkg::token_t       front_tok;
    cst_pkg::token_t       head_tok;
    cst_pkg::back_status_t back_status;
    logic                  front_valid;
    logic                  queue_ready;
    logic                  head_valid;
    logic                  head_pop;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quote_char  <= cst_pkg::QUOTE_RESET;
            cfg_reg.delim_char  <= cst_pkg::DELIM_RESET;
            cfg_reg.trim_enable <= cst_pkg::TRIM_RESET;
        end else if (cfg_we) begin
            if (cfg_index == cst_pkg::REG_QUOTE) begin
                cfg_reg.quote_char <= cfg_wdata;
            end
            if (cfg_index == cst_pkg::REG_DELIM) begin
                cfg_reg.delim_char <= cfg_wdata;
            end
            if (cfg_index == cst_pkg::REG_TRIM) begin
                cfg_reg.trim_enable <= cfg_wdata[0];
            end
        end
    end

    cst_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .tok_valid (front_valid),
        .tok_ready (queue_ready),
        .tok       (front_tok)
    );

    cst_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (queue_ready),
        .push_data  (front_tok),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_data   (head_tok)
    );

    cst_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .trim_enable (cfg_reg.trim_enable),
        .head_valid  (head_valid),
        .head_pop    (head_pop),
        .head        (head_tok),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .status      (back_status)
    );

    // Non-append events carry a zero byte and no overflow flag
    a_nonappend_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] != cst_pkg::EV_APPEND)) |-> ((m_tdata == 8'd0) && !m_tuser[2]))
        else $error("non-append event with byte or overflow set");

    // Held whitespace never exceeds the buffer
    a_hold_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.held_count <= cst_pkg::HOLD_CW'(cst_pkg::HOLD_DEPTH))
        else $error("hold count beyond buffer depth");

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !back_status.busy))
        else $error("output valid after reset");

    // The back pops a word only when one is present and the output register is free
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        head_pop |-> (head_valid && (!m_tvalid || m_tready)))
        else $error("queue popped while output blocked");

endmodule

### hdl/cst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/cst_front.sv
// Front end of the CSV tokenizer: accepts input words and classifies each byte.
// Depends on cst_pkg.
module cst_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  cst_pkg::cfg_t cfg,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // data_byte
    input  logic          s_tuser,   // cmd
    output logic          tok_valid,
    input  logic          tok_ready,
    output cst_pkg::token_t tok
);

    logic            stage_valid_reg;
    cst_pkg::token_t stage_reg;
    cst_pkg::token_t class_next;
    logic            accept;

    // Classify the incoming byte against the configured characters
    always_comb begin
        class_next.flush      = (s_tuser == cst_pkg::CMD_FLUSH);
        class_next.is_quote   = (s_tdata == cfg.quote_char);
        class_next.is_delim   = (s_tdata == cfg.delim_char);
        class_next.is_newline = (s_tdata == cst_pkg::NEWLINE_BYTE);
        class_next.is_space   = cst_pkg::is_space(s_tdata);
        class_next.data_byte  = s_tdata;
    end

    assign s_tready  = !stage_valid_reg || tok_ready;
    assign accept    = s_tvalid && s_tready;
    assign tok_valid = stage_valid_reg;
    assign tok       = stage_reg;

    // Hold the classified word until the queue takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (accept) begin
            stage_valid_reg <= 1'b1;
        end else if (tok_ready) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg <= class_next;
        end
    end

endmodule

### hdl/cst_queue.sv
// Short queue of classified words between the front and the back of the tokenizer.
// Depends on cst_pkg.
module cst_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  cst_pkg::token_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output cst_pkg::token_t pop_data
);

    cst_pkg::token_t                 slot_reg [cst_pkg::QUEUE_DEPTH];
    logic [cst_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [cst_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [cst_pkg::QUEUE_AW:0]      count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = (count_reg != (cst_pkg::QUEUE_AW + 1)'(cst_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/cst_back.sv
// Back end of the CSV tokenizer: parser state, whitespace hold buffer, event output.
// Depends on cst_pkg and cst_ram.
module cst_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  trim_enable,
    input  logic                  head_valid,
    output logic                  head_pop,
    input  cst_pkg::token_t       head,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // out_byte
    output logic [2:0]            m_tuser,   // event_kind[1:0], hold_overflow
    output logic                  m_tlast,   // last
    output cst_pkg::back_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_REL  = 3'b010,
        S_TAIL = 3'b100
    } back_state_t;

    localparam int CW = cst_pkg::HOLD_CW;
    localparam int AW = cst_pkg::HOLD_AW;

    back_state_t state_reg, state_next;

    // Parser state
    logic in_quotes_reg, in_quotes_next;
    logic qpend_reg, qpend_next;
    logic fadded_reg, fadded_next;
    logic fquoted_reg, fquoted_next;
    logic fstarted_reg, fstarted_next;
    logic rowhas_reg, rowhas_next;
    logic [CW-1:0] held_count_reg, held_count_next;
    logic held_ovf_reg, held_ovf_next;

    // Release sequencing and the pending final event
    logic [CW-1:0] rel_idx_reg, rel_idx_next;
    logic [CW-1:0] rel_cnt_reg, rel_cnt_next;
    cst_pkg::event_kind_t tail_kind_reg, tail_kind_next;
    logic [7:0] tail_byte_reg, tail_byte_next;
    logic tail_ovf_reg, tail_ovf_next;

    // Output register
    logic out_valid_reg, out_valid_next;
    cst_pkg::event_kind_t out_kind_reg, out_kind_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic out_ovf_reg, out_ovf_next;
    logic out_last_reg, out_last_next;

    // Hold buffer port
    logic       ram_we;
    logic [7:0] ram_rdata;

    cst_ram #(
        .WIDTH (8),
        .DEPTH (cst_pkg::HOLD_DEPTH)
    ) u_hold (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (held_count_reg[AW-1:0]),
        .wdata (head.data_byte),
        .raddr (rel_idx_next[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Decide events and next state
    always_comb begin
        logic out_free;
        logic unq;
        logic do_eol;
        logic freset;
        logic e0_v;
        cst_pkg::event_kind_t e0_kind;
        logic [7:0] e0_byte;
        logic e0_ovf;
        logic e1_v;
        logic [CW-1:0] rel_inc;

        state_next      = state_reg;
        in_quotes_next  = in_quotes_reg;
        qpend_next      = qpend_reg;
        fadded_next     = fadded_reg;
        fquoted_next    = fquoted_reg;
        fstarted_next   = fstarted_reg;
        rowhas_next     = rowhas_reg;
        held_count_next = held_count_reg;
        held_ovf_next   = held_ovf_reg;
        rel_idx_next    = rel_idx_reg;
        rel_cnt_next    = rel_cnt_reg;
        tail_kind_next  = tail_kind_reg;
        tail_byte_next  = tail_byte_reg;
        tail_ovf_next   = tail_ovf_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        head_pop        = 1'b0;
        unq             = 1'b0;
        do_eol          = 1'b0;
        freset          = 1'b0;
        e0_v            = 1'b0;
        e0_kind         = cst_pkg::EV_APPEND;
        e0_byte         = 8'd0;
        e0_ovf          = 1'b0;
        e1_v            = 1'b0;
        rel_inc         = rel_idx_reg + CW'(1);

        out_free = !out_valid_reg || m_tready;
        if (out_free) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (head_valid && out_free) begin
                    head_pop = 1'b1;
                    // Quoted-field handling and flush
                    if (head.flush) begin
                        in_quotes_next = 1'b0;
                        qpend_next     = 1'b0;
                        do_eol         = 1'b1;
                    end else if (in_quotes_reg) begin
                        if (qpend_reg) begin
                            qpend_next = 1'b0;
                            if (head.is_quote) begin
                                e0_v    = 1'b1;
                                e0_byte = head.data_byte;
                            end else begin
                                in_quotes_next = 1'b0;
                                unq            = 1'b1;
                            end
                        end else if (head.is_quote) begin
                            qpend_next = 1'b1;
                        end else begin
                            e0_v    = 1'b1;
                            e0_byte = head.data_byte;
                        end
                    end else begin
                        unq = 1'b1;
                    end

                    // Byte outside quotes: quote, then delimiter, then newline
                    if (unq) begin
                        priority if (head.is_quote) begin
                            if (fadded_reg) begin
                                e0_v    = 1'b1;
                                e0_kind = cst_pkg::EV_CLEAR;
                            end
                            held_count_next = '0;
                            held_ovf_next   = 1'b0;
                            in_quotes_next  = 1'b1;
                            fquoted_next    = 1'b1;
                            fadded_next     = 1'b1;
                        end else if (head.is_delim) begin
                            e0_v        = 1'b1;
                            e0_kind     = cst_pkg::EV_END_FIELD;
                            rowhas_next = 1'b1;
                            freset      = 1'b1;
                        end else if (head.is_newline) begin
                            do_eol = 1'b1;
                        end else if (!fquoted_reg) begin
                            fadded_next = 1'b1;
                            if (trim_enable && head.is_space) begin
                                if (fstarted_reg) begin
                                    if (held_count_reg < CW'(cst_pkg::HOLD_DEPTH)) begin
                                        ram_we          = 1'b1;
                                        held_count_next = held_count_reg + CW'(1);
                                    end else begin
                                        held_ovf_next = 1'b1;
                                    end
                                end
                            end else begin
                                if (held_count_reg != '0) begin
                                    // Release held whitespace before the byte
                                    state_next     = S_REL;
                                    rel_idx_next   = '0;
                                    rel_cnt_next   = held_count_reg;
                                    tail_kind_next = cst_pkg::EV_APPEND;
                                    tail_byte_next = head.data_byte;
                                    tail_ovf_next  = held_ovf_reg;
                                end else begin
                                    e0_v    = 1'b1;
                                    e0_byte = head.data_byte;
                                    e0_ovf  = held_ovf_reg;
                                end
                                held_count_next = '0;
                                held_ovf_next   = 1'b0;
                                fstarted_next   = 1'b1;
                            end
                        end
                    end

                    // End of line: close a started field, then a non-empty row
                    if (do_eol) begin
                        if (fadded_reg) begin
                            e0_v    = 1'b1;
                            e0_kind = cst_pkg::EV_END_FIELD;
                        end
                        if (fadded_reg || rowhas_reg) begin
                            if (fadded_reg) begin
                                e1_v = 1'b1;
                            end else begin
                                e0_v    = 1'b1;
                                e0_kind = cst_pkg::EV_END_ROW;
                            end
                        end
                        rowhas_next = 1'b0;
                        freset      = 1'b1;
                    end

                    if (freset) begin
                        fadded_next     = 1'b0;
                        fquoted_next    = 1'b0;
                        fstarted_next   = 1'b0;
                        held_count_next = '0;
                        held_ovf_next   = 1'b0;
                    end

                    if (e0_v) begin
                        out_valid_next = 1'b1;
                        out_kind_next  = e0_kind;
                        out_byte_next  = e0_byte;
                        out_ovf_next   = e0_ovf;
                        out_last_next  = !e1_v;
                    end
                    if (e1_v) begin
                        state_next     = S_TAIL;
                        tail_kind_next = cst_pkg::EV_END_ROW;
                        tail_byte_next = 8'd0;
                        tail_ovf_next  = 1'b0;
                    end
                end
            end
            S_REL: begin
                // Emit one held byte per cycle while the output is free
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = cst_pkg::EV_APPEND;
                    out_byte_next  = ram_rdata;
                    out_ovf_next   = tail_ovf_reg;
                    out_last_next  = 1'b0;
                    rel_idx_next   = rel_inc;
                    if (rel_inc == rel_cnt_reg) begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = tail_kind_reg;
                    out_byte_next  = tail_byte_reg;
                    out_ovf_next   = tail_ovf_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            in_quotes_reg  <= 1'b0;
            qpend_reg      <= 1'b0;
            fadded_reg     <= 1'b0;
            fquoted_reg    <= 1'b0;
            fstarted_reg   <= 1'b0;
            rowhas_reg     <= 1'b0;
            held_count_reg <= '0;
            held_ovf_reg   <= 1'b0;
            rel_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            in_quotes_reg  <= in_quotes_next;
            qpend_reg      <= qpend_next;
            fadded_reg     <= fadded_next;
            fquoted_reg    <= fquoted_next;
            fstarted_reg   <= fstarted_next;
            rowhas_reg     <= rowhas_next;
            held_count_reg <= held_count_next;
            held_ovf_reg   <= held_ovf_next;
            rel_idx_reg    <= rel_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rel_cnt_reg   <= rel_cnt_next;
        tail_kind_reg <= tail_kind_next;
        tail_byte_reg <= tail_byte_next;
        tail_ovf_reg  <= tail_ovf_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_ovf_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

    assign status.busy       = (state_reg != S_IDLE) || out_valid_reg;
    assign status.held_count = held_count_reg;

endmodule
